>>> design/irie_pkg.sv
// ----------------------------------------------------------------------------
// irie_pkg
// Shared types and constants for the ICMP reply identifier extractor.
// ----------------------------------------------------------------------------
package irie_pkg;

  typedef enum logic [1:0] {
    KIND_INVALID  = 2'd0,
    KIND_ECHO     = 2'd1,
    KIND_TIME_EXC = 2'd2
  } reply_kind_t;

  typedef enum logic [1:0] {
    VER_UNKNOWN = 2'd0,
    VER_IPV4    = 2'd1,
    VER_IPV6    = 2'd2,
    VER_UNUSED  = 2'd3
  } ip_ver_t;

  localparam logic [7:0] V4_ECHO_REPLY    = 8'd0;
  localparam logic [7:0] V4_TIME_EXCEEDED = 8'd11;
  localparam logic [7:0] V6_ECHO_REPLY    = 8'd129;
  localparam logic [7:0] V6_TIME_EXCEEDED = 8'd3;
  localparam logic [7:0] QUOTE_SKIP       = 8'h08;
  localparam logic [7:0] V6_QUOTE_START   = 8'd48;
  localparam logic [7:0] OFFSET_MAX       = 8'd255;

endpackage

>>> design/icmp_reply_id_extractor.sv
// ----------------------------------------------------------------------------
// icmp_reply_id_extractor
// Parses a received ICMP packet byte by byte and reports the echo identifier
// and sequence number of an echo reply or of the request quoted in a time
// exceeded message.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid in_stall in_data_byte          | word in
//          | in_last_byte                            |
//  out     | out_valid out_stall out_reply_kind      | word out
//          | out_ident out_seq_number                |
//  cfg     | cfg_wr_en cfg_wr_data (ip_version)      | write only
//
// One word per clock is accepted while in_stall is low. A word passes an
// input register, then the parse logic updates the packet state; a last-byte
// word loads the result register. in_stall is raised only while the input
// register holds a last byte and a result waits under out_stall. Reset
// (rst_n, synchronous) clears the pipeline valids, the packet state and
// ip_version.
// ----------------------------------------------------------------------------
module icmp_reply_id_extractor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_reply_kind,
  output logic [15:0] out_ident,
  output logic [15:0] out_seq_number,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data
);

  logic [1:0]  ip_version_r;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;

  logic [7:0]  byte_offset_r, byte_offset_nxt;
  logic [5:0]  outer_len_r, outer_len_nxt;
  logic [5:0]  inner_len_r, inner_len_nxt;
  logic [7:0]  msg_type_r, msg_type_nxt;
  logic [7:0]  msg_code_r, msg_code_nxt;
  logic [15:0] ident_acc_r, ident_acc_nxt;
  logic [15:0] seq_acc_r, seq_acc_nxt;
  logic        fields_seen_r, fields_seen_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_kind_r, out_kind_nxt;
  logic [15:0] out_ident_r, out_ident_nxt;
  logic [15:0] out_seq_r, out_seq_nxt;

  logic        advance;
  logic        s1_load;
  logic        is_v4, is_v6;
  logic [7:0]  pos, hdr, base;
  logic        take;
  logic [1:0]  kind;

  // A non-last word never produces a result, so it may leave the input
  // register even while the result register is blocked.
  assign advance  = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign s1_load  = in_valid && !in_stall;

  assign is_v4 = (ip_version_r == irie_pkg::VER_IPV4);
  assign is_v6 = (ip_version_r == irie_pkg::VER_IPV6);
  assign pos   = byte_offset_r;

  always_comb begin
    outer_len_nxt   = outer_len_r;
    inner_len_nxt   = inner_len_r;
    msg_type_nxt    = msg_type_r;
    msg_code_nxt    = msg_code_r;
    ident_acc_nxt   = ident_acc_r;
    seq_acc_nxt     = seq_acc_r;
    fields_seen_nxt = fields_seen_r;
    byte_offset_nxt = byte_offset_r;
    hdr             = 8'd0;
    base            = 8'd0;
    take            = 1'b0;
    kind            = irie_pkg::KIND_INVALID;

    if (is_v4) begin
      if (pos == 8'd0) begin
        outer_len_nxt = {s1_byte_r[3:0], 2'b00};
      end
      hdr = {2'b00, outer_len_nxt};
      if (pos == hdr) begin
        msg_type_nxt = s1_byte_r;
      end
      if (pos == hdr + 8'd1) begin
        msg_code_nxt = s1_byte_r;
      end
      if (msg_type_nxt == irie_pkg::V4_ECHO_REPLY) begin
        base = hdr;
        take = 1'b1;
      end else if (msg_type_nxt == irie_pkg::V4_TIME_EXCEEDED) begin
        if (pos == hdr + irie_pkg::QUOTE_SKIP) begin
          inner_len_nxt = {s1_byte_r[3:0], 2'b00};
        end
        base = hdr + irie_pkg::QUOTE_SKIP + {2'b00, inner_len_nxt};
        take = 1'b1;
      end
    end else if (is_v6) begin
      if (pos == 8'd0) begin
        msg_type_nxt = s1_byte_r;
      end
      if (pos == 8'd1) begin
        msg_code_nxt = s1_byte_r;
      end
      if (msg_type_nxt == irie_pkg::V6_ECHO_REPLY) begin
        base = 8'd0;
        take = 1'b1;
      end else if (msg_type_nxt == irie_pkg::V6_TIME_EXCEEDED) begin
        base = irie_pkg::V6_QUOTE_START;
        take = 1'b1;
      end
    end

    if (take) begin
      if (pos == base + 8'd4) ident_acc_nxt[15:8] = s1_byte_r;
      if (pos == base + 8'd5) ident_acc_nxt[7:0]  = s1_byte_r;
      if (pos == base + 8'd6) seq_acc_nxt[15:8]   = s1_byte_r;
      if (pos == base + 8'd7) begin
        seq_acc_nxt[7:0] = s1_byte_r;
        fields_seen_nxt  = 1'b1;
      end
    end

    if (fields_seen_nxt && msg_code_nxt == 8'd0) begin
      if (is_v4) begin
        if (msg_type_nxt == irie_pkg::V4_ECHO_REPLY) begin
          kind = irie_pkg::KIND_ECHO;
        end else if (msg_type_nxt == irie_pkg::V4_TIME_EXCEEDED) begin
          kind = irie_pkg::KIND_TIME_EXC;
        end
      end else if (is_v6) begin
        if (msg_type_nxt == irie_pkg::V6_ECHO_REPLY) begin
          kind = irie_pkg::KIND_ECHO;
        end else if (msg_type_nxt == irie_pkg::V6_TIME_EXCEEDED) begin
          kind = irie_pkg::KIND_TIME_EXC;
        end
      end
    end

    if (byte_offset_r != irie_pkg::OFFSET_MAX) begin
      byte_offset_nxt = byte_offset_r + 8'd1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_ident_nxt = out_ident_r;
    out_seq_nxt   = out_seq_r;
    if (advance && s1_last_r) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = kind;
      out_ident_nxt = (kind == irie_pkg::KIND_INVALID) ? 16'd0 : ident_acc_nxt;
      out_seq_nxt   = (kind == irie_pkg::KIND_INVALID) ? 16'd0 : seq_acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ip_version_r  <= irie_pkg::VER_UNKNOWN;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      byte_offset_r <= 8'd0;
      outer_len_r   <= 6'd0;
      inner_len_r   <= 6'd0;
      msg_type_r    <= 8'd0;
      msg_code_r    <= 8'd0;
      ident_acc_r   <= 16'd0;
      seq_acc_r     <= 16'd0;
      fields_seen_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        ip_version_r <= cfg_wr_data;
      end
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        if (s1_last_r) begin
          byte_offset_r <= 8'd0;
          outer_len_r   <= 6'd0;
          inner_len_r   <= 6'd0;
          msg_type_r    <= 8'd0;
          msg_code_r    <= 8'd0;
          ident_acc_r   <= 16'd0;
          seq_acc_r     <= 16'd0;
          fields_seen_r <= 1'b0;
        end else begin
          byte_offset_r <= byte_offset_nxt;
          outer_len_r   <= outer_len_nxt;
          inner_len_r   <= inner_len_nxt;
          msg_type_r    <= msg_type_nxt;
          msg_code_r    <= msg_code_nxt;
          ident_acc_r   <= ident_acc_nxt;
          seq_acc_r     <= seq_acc_nxt;
          fields_seen_r <= fields_seen_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
    out_kind_r  <= out_kind_nxt;
    out_ident_r <= out_ident_nxt;
    out_seq_r   <= out_seq_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_reply_kind = out_kind_r;
  assign out_ident      = out_ident_r;
  assign out_seq_number = out_seq_r;

endmodule

>>> design/irie_checker.sv
// ----------------------------------------------------------------------------
// irie_checker
// Port-level checks for the ICMP reply identifier extractor.
// ----------------------------------------------------------------------------
module irie_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_reply_kind,
  input logic [15:0] out_ident,
  input logic [15:0] out_seq_number
);

  // A held result keeps its word until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_reply_kind)
      && $stable(out_ident) && $stable(out_seq_number))
    else $error("result changed while stalled");

  // The input side only backs up behind a blocked result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_reply_kind == irie_pkg::KIND_INVALID
      || out_reply_kind == irie_pkg::KIND_ECHO
      || out_reply_kind == irie_pkg::KIND_TIME_EXC)
    else $error("unused reply kind code");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reply_kind == irie_pkg::KIND_INVALID
      |-> out_ident == 16'd0 && out_seq_number == 16'd0)
    else $error("invalid result carries nonzero fields");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind icmp_reply_id_extractor irie_checker u_irie_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_reply_kind (out_reply_kind),
  .out_ident      (out_ident),
  .out_seq_number (out_seq_number)
);

>>> bench/tb_icmp_reply_id_extractor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_icmp_reply_id_extractor
// Drives packets byte by byte into the ICMP reply identifier extractor under
// every ip_version setting and checks each reply word against a cycle-free
// parser model kept in this bench. Both channels see random gaps and stalls,
// and one long receiver hold backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_icmp_reply_id_extractor;

  localparam int CLK_HALF     = 5;
  localparam int LIMIT_CYCLES = 400000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_BYTES  = 12;
  localparam int REPORT_MAX   = 10;
  localparam logic [7:0] ECHO_REQUEST = 8'd8;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } wire_word_t;

  typedef struct {
    irie_pkg::reply_kind_t kind;
    logic [15:0] ident;
    logic [15:0] seq;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_reply_kind;
  logic [15:0] out_ident;
  logic [15:0] out_seq_number;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = 2'd0;

  icmp_reply_id_extractor dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_reply_kind (out_reply_kind),
    .out_ident      (out_ident),
    .out_seq_number (out_seq_number),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always #CLK_HALF clk = ~clk;

  // Bench-side parser state, mirrors the packet state of the block.
  irie_pkg::ip_ver_t cur_version = irie_pkg::VER_UNKNOWN;
  logic [7:0]  at_offset = 8'd0;
  logic [5:0]  outer_len = 6'd0;
  logic [5:0]  inner_len = 6'd0;
  logic [7:0]  icmp_ty = 8'd0;
  logic [7:0]  icmp_cd = 8'd0;
  logic [15:0] id_hold = 16'd0;
  logic [15:0] seq_hold = 16'd0;
  logic        idseq_done = 1'b0;

  wire_word_t  tx_words[$];
  reply_t      pending_replies[$];
  logic [7:0]  pkt_buf[$];
  wire_word_t  tx_head;

  bit word_accepted = 1'b0;
  int tx_gap = 0;
  int rx_gap = 0;
  int tx_mode = 1;
  int rx_mode = 1;
  int hold_left = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int cycle_count = 0;
  int fail_count = 0;
  int words_queued = 0;
  int pkts_sent = 0;
  int echo_seen = 0;
  int te_seen = 0;
  int invalid_seen = 0;

  function automatic int draw_gap(input int mode);
    int r;
    if (mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_byte();
    logic [31:0] r;
    r = $urandom;
    return r[7:0];
  endfunction

  function automatic void clear_packet_state();
    at_offset  = 8'd0;
    outer_len  = 6'd0;
    inner_len  = 6'd0;
    icmp_ty    = 8'd0;
    icmp_cd    = 8'd0;
    id_hold    = 16'd0;
    seq_hold   = 16'd0;
    idseq_done = 1'b0;
  endfunction

  // Identifier and sequence sit at bytes 4..7 of an echo header at base.
  function automatic void grab_idseq(input int pos, input int base, input logic [7:0] b);
    if (pos == base + 4) id_hold[15:8] = b;
    if (pos == base + 5) id_hold[7:0] = b;
    if (pos == base + 6) seq_hold[15:8] = b;
    if (pos == base + 7) begin
      seq_hold[7:0] = b;
      idseq_done = 1'b1;
    end
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic is_last);
    int pos;
    int h;
    irie_pkg::reply_kind_t k;
    reply_t r;
    pos = int'(at_offset);
    k = irie_pkg::KIND_INVALID;
    if (cur_version == irie_pkg::VER_IPV4) begin
      if (pos == 0) outer_len = {b[3:0], 2'b00};
      h = int'(outer_len);
      if (pos == h) icmp_ty = b;
      if (pos == h + 1) icmp_cd = b;
      if (icmp_ty == irie_pkg::V4_ECHO_REPLY) begin
        grab_idseq(pos, h, b);
      end else if (icmp_ty == irie_pkg::V4_TIME_EXCEEDED) begin
        if (pos == h + int'(irie_pkg::QUOTE_SKIP)) inner_len = {b[3:0], 2'b00};
        grab_idseq(pos, h + int'(irie_pkg::QUOTE_SKIP) + int'(inner_len), b);
      end
    end else if (cur_version == irie_pkg::VER_IPV6) begin
      if (pos == 0) icmp_ty = b;
      if (pos == 1) icmp_cd = b;
      if (icmp_ty == irie_pkg::V6_ECHO_REPLY) grab_idseq(pos, 0, b);
      else if (icmp_ty == irie_pkg::V6_TIME_EXCEEDED)
        grab_idseq(pos, int'(irie_pkg::V6_QUOTE_START), b);
    end
    if (at_offset != irie_pkg::OFFSET_MAX) at_offset = at_offset + 8'd1;
    if (is_last) begin
      if (idseq_done && icmp_cd == 8'd0) begin
        if (cur_version == irie_pkg::VER_IPV4) begin
          if (icmp_ty == irie_pkg::V4_ECHO_REPLY) k = irie_pkg::KIND_ECHO;
          else if (icmp_ty == irie_pkg::V4_TIME_EXCEEDED) k = irie_pkg::KIND_TIME_EXC;
        end else if (cur_version == irie_pkg::VER_IPV6) begin
          if (icmp_ty == irie_pkg::V6_ECHO_REPLY) k = irie_pkg::KIND_ECHO;
          else if (icmp_ty == irie_pkg::V6_TIME_EXCEEDED) k = irie_pkg::KIND_TIME_EXC;
        end
      end
      r.kind  = k;
      r.ident = (k != irie_pkg::KIND_INVALID) ? id_hold : 16'h0000;
      r.seq   = (k != irie_pkg::KIND_INVALID) ? seq_hold : 16'h0000;
      pending_replies.push_back(r);
      clear_packet_state();
    end
  endfunction

  task automatic check_reply();
    reply_t want;
    if (pending_replies.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_MAX)
        $display("ERROR: reply word with none expected: kind %0d ident %h seq %h",
                 out_reply_kind, out_ident, out_seq_number);
    end else begin
      want = pending_replies.pop_front();
      if (out_reply_kind !== want.kind || out_ident !== want.ident ||
          out_seq_number !== want.seq) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("ERROR: reply mismatch: kind %0d/%0d ident %h/%h seq %h/%h (exp/got)",
                   want.kind, out_reply_kind, want.ident, out_ident,
                   want.seq, out_seq_number);
      end
    end
    case (out_reply_kind)
      irie_pkg::KIND_ECHO:     echo_seen++;
      irie_pkg::KIND_TIME_EXC: te_seen++;
      default:                 invalid_seen++;
    endcase
  endtask

  // Monitor: both handshakes are sampled on the rising edge.
  always @(posedge clk) begin
    word_accepted = rst_n && in_valid && !in_stall;
    if (word_accepted) parse_byte(in_data_byte, in_last_byte);
    if (rst_n && out_valid && !out_stall) check_reply();
  end

  // Driver: a word is held until accepted, then a random gap may follow.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || word_accepted)) begin
      if (tx_gap > 0) begin
        in_valid <= 1'b0;
        tx_gap--;
      end else if (tx_words.size() > 0) begin
        tx_head = tx_words.pop_front();
        in_valid <= 1'b1;
        in_data_byte <= tx_head.data;
        in_last_byte <= tx_head.is_last;
        tx_gap = draw_gap(tx_mode);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold whenever one is requested.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else if (rx_gap > 0) begin
      out_stall <= 1'b1;
      rx_gap--;
    end else begin
      out_stall <= 1'b0;
      rx_gap = draw_gap(rx_mode);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("ERROR: timeout with %0d replies outstanding", pending_replies.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic drain_block();
    while (tx_words.size() != 0 || in_valid || pending_replies.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_version(input irie_pkg::ip_ver_t v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    cur_version = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic fill_random(input int len);
    pkt_buf.delete();
    repeat (len) pkt_buf.push_back(rand_byte());
  endtask

  task automatic put_byte(input int pos, input logic [7:0] val);
    if (pos < pkt_buf.size()) pkt_buf[pos] = val;
  endtask

  task automatic put_ihl(input int pos, input int ihl);
    if (pos < pkt_buf.size()) pkt_buf[pos] = {pkt_buf[pos][7:4], ihl[3:0]};
  endtask

  task automatic put_idseq(input int base, input logic [15:0] id, input logic [15:0] sq);
    put_byte(base + 4, id[15:8]);
    put_byte(base + 5, id[7:0]);
    put_byte(base + 6, sq[15:8]);
    put_byte(base + 7, sq[7:0]);
  endtask

  // An IPv4 packet: outer header, ICMP header and, for time exceeded, the
  // quoted header and request. extra trims or pads the needed length.
  task automatic build_v4(input logic [7:0] ty, input logic [7:0] code, input int oihl,
                          input int iihl, input int extra);
    int h;
    int len;
    h = oihl * 4;
    len = (ty == irie_pkg::V4_TIME_EXCEEDED) ? h + 16 + iihl * 4 : h + 8;
    len = len + extra;
    if (len < 1) len = 1;
    fill_random(len);
    put_ihl(0, oihl);
    put_byte(h, ty);
    put_byte(h + 1, code);
    if (ty == irie_pkg::V4_TIME_EXCEEDED) put_ihl(h + 8, iihl);
  endtask

  task automatic build_v6(input logic [7:0] ty, input logic [7:0] code, input int extra);
    int len;
    len = (ty == irie_pkg::V6_TIME_EXCEEDED) ? int'(irie_pkg::V6_QUOTE_START) + 8 : 8;
    len = len + extra;
    if (len < 1) len = 1;
    fill_random(len);
    put_byte(0, ty);
    put_byte(1, code);
  endtask

  task automatic send_slice(input int lo, input int hi, input bit mark_last);
    wire_word_t w;
    int i;
    for (i = lo; i <= hi; i++) begin
      w.data = pkt_buf[i];
      w.is_last = mark_last && (i == hi);
      tx_words.push_back(w);
      words_queued++;
    end
    if (mark_last) pkts_sent++;
  endtask

  task automatic send_packet();
    send_slice(0, pkt_buf.size() - 1, 1'b1);
  endtask

  // Mostly well-formed replies with random content; the rest is noise,
  // short packets, odd codes or types, and now and then a very long packet.
  task automatic random_packet(input bit v6_shape);
    int r;
    int extra;
    int oihl;
    int iihl;
    logic [7:0] ty;
    logic [7:0] code;
    r = $urandom_range(0, 99);
    extra = $urandom_range(0, 6);
    if ($urandom_range(0, 9) == 0) begin
      extra = $urandom_range(1, 8);
      extra = -extra;
    end
    if ($urandom_range(0, 49) == 0) extra = $urandom_range(200, 260);
    oihl = ($urandom_range(0, 9) < 7) ? 5 : $urandom_range(0, 15);
    iihl = ($urandom_range(0, 9) < 7) ? 5 : $urandom_range(0, 15);
    code = ($urandom_range(0, 9) == 0) ? rand_byte() : 8'd0;
    if (r < 15) begin
      fill_random($urandom_range(1, 40));
    end else if (v6_shape) begin
      ty = (r < 55) ? irie_pkg::V6_ECHO_REPLY :
           (r < 92) ? irie_pkg::V6_TIME_EXCEEDED : rand_byte();
      build_v6(ty, code, extra);
    end else begin
      ty = (r < 55) ? irie_pkg::V4_ECHO_REPLY :
           (r < 92) ? irie_pkg::V4_TIME_EXCEEDED : rand_byte();
      build_v4(ty, code, oihl, iihl, extra);
    end
    send_packet();
  endtask

  initial begin
    int ph;
    int phase_start;
    irie_pkg::ip_ver_t v;
    bit v6_shape;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset value of the version register rejects everything.
    build_v4(irie_pkg::V4_ECHO_REPLY, 8'd0, 5, 5, 0);
    send_packet();
    drain_block();

    set_version(irie_pkg::VER_IPV4);
    build_v4(irie_pkg::V4_ECHO_REPLY, 8'd0, 5, 5, 0);
    put_idseq(20, 16'hFFFF, 16'h0000);
    send_packet();
    build_v4(irie_pkg::V4_ECHO_REPLY, 8'd0, 15, 5, 3);
    put_idseq(60, 16'h0000, 16'hFFFF);
    send_packet();
    build_v4(irie_pkg::V4_TIME_EXCEEDED, 8'd0, 5, 5, 0);
    send_packet();
    build_v4(irie_pkg::V4_TIME_EXCEEDED, 8'd0, 15, 15, 2);
    put_idseq(60 + 8 + 60, 16'hA55A, 16'h5AA5);
    send_packet();
    // Zero header lengths: the following structure begins on the same byte.
    build_v4(irie_pkg::V4_ECHO_REPLY, 8'd0, 0, 5, 0);
    send_packet();
    build_v4(irie_pkg::V4_TIME_EXCEEDED, 8'd0, 5, 0, 0);
    send_packet();
    build_v4(irie_pkg::V4_ECHO_REPLY, 8'd1, 5, 5, 0);
    send_packet();
    build_v4(ECHO_REQUEST, 8'd0, 5, 5, 0);
    send_packet();
    build_v4(irie_pkg::V4_ECHO_REPLY, 8'd0, 5, 5, -1);
    send_packet();
    fill_random(1);
    send_packet();
    // Runs the offset counter into saturation.
    build_v4(irie_pkg::V4_ECHO_REPLY, 8'd0, 5, 5, 250);
    send_packet();
    drain_block();

    set_version(irie_pkg::VER_IPV6);
    build_v6(irie_pkg::V6_ECHO_REPLY, 8'd0, 0);
    put_idseq(0, 16'hFFFF, 16'hFFFF);
    send_packet();
    build_v6(irie_pkg::V6_TIME_EXCEEDED, 8'd0, 1);
    send_packet();
    build_v6(irie_pkg::V6_ECHO_REPLY, 8'hFF, 0);
    send_packet();
    build_v6(irie_pkg::V4_ECHO_REPLY, 8'd0, 0);
    send_packet();
    build_v6(irie_pkg::V6_TIME_EXCEEDED, 8'd0, -1);
    send_packet();
    drain_block();

    set_version(irie_pkg::VER_UNUSED);
    build_v6(irie_pkg::V6_ECHO_REPLY, 8'd0, 0);
    send_packet();
    build_v4(irie_pkg::V4_ECHO_REPLY, 8'd0, 5, 5, 0);
    send_packet();
    drain_block();

    // Version rewritten in the middle of a packet, with the block drained.
    set_version(irie_pkg::VER_IPV6);
    build_v6(irie_pkg::V6_ECHO_REPLY, 8'd0, 2);
    send_slice(0, 3, 1'b0);
    drain_block();
    set_version(irie_pkg::VER_IPV4);
    send_slice(4, pkt_buf.size() - 1, 1'b1);
    drain_block();
    set_version(irie_pkg::VER_IPV6);
    build_v6(irie_pkg::V6_ECHO_REPLY, 8'd0, 0);
    send_slice(0, pkt_buf.size() - 2, 1'b0);
    drain_block();
    set_version(irie_pkg::VER_UNKNOWN);
    send_slice(pkt_buf.size() - 1, pkt_buf.size() - 1, 1'b1);
    drain_block();

    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: v = irie_pkg::VER_IPV4;
        1: v = irie_pkg::VER_IPV6;
        2: v = (ph < 4) ? irie_pkg::VER_UNKNOWN : irie_pkg::VER_UNUSED;
        default: v = (ph < 4) ? irie_pkg::VER_IPV4 : irie_pkg::VER_IPV6;
      endcase
      set_version(v);
      tx_mode = (ph % 3 == 2) ? 0 : 1;
      rx_mode = (ph % 3 == 1) ? 0 : 1;
      phase_start = words_queued;
      while (words_queued - phase_start < PHASE_BYTES) begin
        if (v == irie_pkg::VER_IPV4) v6_shape = 1'b0;
        else if (v == irie_pkg::VER_IPV6) v6_shape = 1'b1;
        else v6_shape = $urandom_range(0, 1);
        random_packet(v6_shape);
      end
      drain_block();
    end

    // Back-pressure: short replies at full rate against a long receiver hold.
    set_version(irie_pkg::VER_IPV6);
    tx_mode = 0;
    rx_mode = 1;
    hold_requests++;
    repeat (12) begin
      build_v6(irie_pkg::V6_ECHO_REPLY, 8'd0, 0);
      send_packet();
    end
    drain_block();
    repeat (10) @(posedge clk);

    $display("Covered %0d packets (%0d bytes) under all four version codes, with a",
             pkts_sent, words_queued);
    $display("mid-packet version change and a long hold: %0d echo, %0d TTL, %0d invalid.",
             echo_seen, te_seen, invalid_seen);
    if (fail_count == 0 && pending_replies.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("ERROR: %0d failures, %0d replies outstanding", fail_count,
               pending_replies.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
